// ----- rtl/core/olid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the ordered list block.
package olid_pkg;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int LCOUNT_W = 7;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_EDIT   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCNT = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_TAKE_HEAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/olid_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list chain: holds a word and moves it to a neighbor.
module olid_cell (
    input  logic                                aclk,
    input  olid_pkg::cell_ctrl_t                ctrl,
    input  logic [olid_pkg::WORD_W-1:0]         load_word,
    input  logic [olid_pkg::WORD_W-1:0]         left_word,
    input  logic [olid_pkg::WORD_W-1:0]         right_word,
    input  logic [olid_pkg::WORD_W-1:0]         head_word,
    output logic [olid_pkg::WORD_W-1:0]         word
);

    logic [olid_pkg::WORD_W-1:0] word_reg;
    logic [olid_pkg::WORD_W-1:0] word_next;

    always_comb begin
        case (ctrl.op)
            olid_pkg::CELL_WRITE:      word_next = load_word;
            olid_pkg::CELL_TAKE_LEFT:  word_next = left_word;
            olid_pkg::CELL_TAKE_RIGHT: word_next = right_word;
            olid_pkg::CELL_TAKE_HEAD:  word_next = head_word;
            default:                   word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- rtl/core/ordered_list_insert_delete_top.sv -----
`timescale 1ns / 1ps
// Top level of the ordered list: control, output register and the cell chain.
//
// Ordered list of up to CAPACITY signed 32-bit words held in a chain of cells.
// For load, insert, edit and delete, every cell picks its new word from itself,
// a neighbor or the input in the same clock, so an insert or delete shifts the
// words from its position upward at once. Read all first enters its read state
// and then emits one word per cycle while the output is not stalled, count_now
// transfers in total; the chain rotates by one with each word so the head
// cell always holds the next word, and after the last word the list is back
// in place. No input transfer is taken while a read is running. One output
// register sits between the chain and m_*, and a new input transfer is taken
// while that register drains. Opcodes 5 to 7 are taken and give no result.
// Words below the count that were never loaded read as anything.
module ordered_list_insert_delete_top #(
    parameter int CAPACITY = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] position, [39:8] word_in, [46:40] load_count, [47] zero
    input  logic [olid_pkg::S_DATA_W-1:0]     s_tdata,
    // [2:0] opcode
    input  logic [olid_pkg::OPCODE_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] word_out, [37:32] word_index, [44:38] count_now, [47:45] zero
    output logic [olid_pkg::M_DATA_W-1:0]     m_tdata,
    // [2:0] status
    output logic [olid_pkg::STATUS_W-1:0]     m_tuser,
    output logic                              m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [IW-1:0]                   rd_idx_reg, rd_idx_next;

    logic                            m_valid_reg, m_valid_next;
    logic [olid_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [olid_pkg::WORD_W-1:0]     word_reg, word_next;
    logic [olid_pkg::INDEX_W-1:0]    index_reg, index_next;
    logic [olid_pkg::COUNT_W-1:0]    count_reg;
    logic                            last_reg, last_next;
    logic                            out_load;

    logic [olid_pkg::OPCODE_W-1:0]   op;
    logic [olid_pkg::POS_W-1:0]      pos;
    logic [olid_pkg::WORD_W-1:0]     win;
    logic [olid_pkg::LCOUNT_W-1:0]   lcnt;
    logic                            accept;
    logic                            out_free;
    logic [olid_pkg::POS_W-1:0]      cnt8;
    logic [olid_pkg::POS_W-1:0]      ins_pos;
    logic [olid_pkg::WORD_W-1:0]     sel_word;
    logic                            rd_last;

    olid_pkg::cell_ctrl_t            cell_ctrl [CAPACITY];
    logic [olid_pkg::WORD_W-1:0]     cell_word [CAPACITY];

    assign op   = s_tuser;
    assign pos  = s_tdata[7:0];
    assign win  = s_tdata[39:8];
    assign lcnt = s_tdata[46:40];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign cnt8     = olid_pkg::POS_W'(cnt_reg);
    assign rd_last  = CW'(rd_idx_reg) == (cnt_reg - CW'(1));

    always_comb begin
        if (pos[olid_pkg::POS_W-1]) begin
            ins_pos = '0;
        end else if (pos > cnt8) begin
            ins_pos = cnt8;
        end else begin
            ins_pos = pos;
        end
    end

    always_comb begin
        sel_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos == olid_pkg::POS_W'(i)) begin
                sel_word = sel_word | cell_word[i];
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        out_load    = 1'b0;
        status_next = olid_pkg::ST_OK;
        word_next   = '0;
        index_next  = '0;
        last_next   = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctrl[i].op = olid_pkg::CELL_HOLD;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        olid_pkg::OP_LOAD: begin
                            out_load = 1'b1;
                            if (lcnt == '0 || lcnt > olid_pkg::LCOUNT_W'(CAPACITY)) begin
                                status_next = olid_pkg::ST_BADCNT;
                            end else if (pos[olid_pkg::POS_W-1]
                                         || pos >= olid_pkg::POS_W'(lcnt)) begin
                                status_next = olid_pkg::ST_BADIDX;
                            end else begin
                                cnt_next   = lcnt[CW-1:0];
                                index_next = pos[olid_pkg::INDEX_W-1:0];
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (pos == olid_pkg::POS_W'(i)) begin
                                        cell_ctrl[i].op = olid_pkg::CELL_WRITE;
                                    end
                                end
                            end
                        end
                        olid_pkg::OP_READ: begin
                            if (cnt_reg == '0) begin
                                out_load    = 1'b1;
                                status_next = olid_pkg::ST_EMPTY;
                            end else begin
                                state_next  = S_READ;
                                rd_idx_next = '0;
                            end
                        end
                        olid_pkg::OP_INSERT: begin
                            out_load = 1'b1;
                            if (cnt_reg == CW'(CAPACITY)) begin
                                status_next = olid_pkg::ST_FULL;
                            end else begin
                                cnt_next   = cnt_reg + CW'(1);
                                index_next = ins_pos[olid_pkg::INDEX_W-1:0];
                                // only the used part moves up; cells above it keep their words
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (ins_pos == olid_pkg::POS_W'(i)) begin
                                        cell_ctrl[i].op = olid_pkg::CELL_WRITE;
                                    end else if (ins_pos < olid_pkg::POS_W'(i)
                                                 && olid_pkg::POS_W'(i) <= cnt8) begin
                                        cell_ctrl[i].op = olid_pkg::CELL_TAKE_LEFT;
                                    end
                                end
                            end
                        end
                        olid_pkg::OP_EDIT: begin
                            out_load = 1'b1;
                            if (pos[olid_pkg::POS_W-1] || pos >= cnt8) begin
                                status_next = olid_pkg::ST_BADIDX;
                            end else begin
                                word_next  = sel_word;
                                index_next = pos[olid_pkg::INDEX_W-1:0];
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (pos == olid_pkg::POS_W'(i)) begin
                                        cell_ctrl[i].op = olid_pkg::CELL_WRITE;
                                    end
                                end
                            end
                        end
                        olid_pkg::OP_DELETE: begin
                            out_load = 1'b1;
                            if (pos[olid_pkg::POS_W-1] || pos >= cnt8) begin
                                status_next = olid_pkg::ST_BADIDX;
                            end else begin
                                cnt_next   = cnt_reg - CW'(1);
                                index_next = pos[olid_pkg::INDEX_W-1:0];
                                // the top used cell keeps its word
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (pos <= olid_pkg::POS_W'(i)
                                        && olid_pkg::POS_W'(i + 1) < cnt8) begin
                                        cell_ctrl[i].op = olid_pkg::CELL_TAKE_RIGHT;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    word_next   = cell_word[0];
                    index_next  = olid_pkg::INDEX_W'(rd_idx_reg);
                    last_next   = rd_last;
                    rd_idx_next = rd_idx_reg + IW'(1);
                    // rotate the used part of the chain by one
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CW'(i) == cnt_reg - CW'(1)) begin
                            cell_ctrl[i].op = olid_pkg::CELL_TAKE_HEAD;
                        end else if (CW'(i) < cnt_reg) begin
                            cell_ctrl[i].op = olid_pkg::CELL_TAKE_RIGHT;
                        end
                    end
                    if (rd_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= status_next;
            word_reg   <= word_next;
            index_reg  <= index_next;
            count_reg  <= olid_pkg::COUNT_W'(cnt_next);
            last_reg   <= last_next;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        olid_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[g]),
            .load_word  (win),
            .left_word  (cell_word[(g == 0) ? 0 : g - 1]),
            .right_word (cell_word[(g == CAPACITY - 1) ? 0 : g + 1]),
            .head_word  (cell_word[0]),
            .word       (cell_word[g])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, count_reg, index_reg, word_reg};

endmodule

// ----- rtl/core/olid_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the ordered list top level, bound to it.
module olid_checker #(
    parameter int CAPACITY = 8
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [olid_pkg::M_DATA_W-1:0]     m_tdata,
    input logic [olid_pkg::STATUS_W-1:0]     m_tuser,
    input logic                              m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != olid_pkg::ST_OK |-> m_tlast)
        else $error("error result not marked last");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != olid_pkg::ST_OK |-> m_tdata[37:0] == '0)
        else $error("error result carries word or index");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[44:38] <= olid_pkg::COUNT_W'(CAPACITY))
        else $error("count above capacity");

    a_read_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid
            && m_tdata[37:32] == $past(m_tdata[37:32]) + 6'd1)
        else $error("read index did not advance");

endmodule

bind ordered_list_insert_delete_top olid_checker #(.CAPACITY(CAPACITY)) u_olid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/tb_ordered_list_insert_delete_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list block: directed table, random ops, scoreboard.
module tb_ordered_list_insert_delete_top;

    localparam int CAPACITY    = 8;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CLK_PERIOD  = 4;
    localparam int RESET_LEN   = 8;
    localparam int RANDOM_OPS  = 180;
    localparam int HOLD_OFF    = 300;
    localparam int DRAIN_LEN   = 20;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [olid_pkg::OPCODE_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [olid_pkg::OPCODE_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [olid_pkg::OPCODE_W-1:0] op;
        logic [olid_pkg::POS_W-1:0]    pos;
        logic [olid_pkg::WORD_W-1:0]   word;
        logic [olid_pkg::LCOUNT_W-1:0] lcnt;
    } list_cmd_t;

    typedef struct packed {
        logic [olid_pkg::STATUS_W-1:0] status;
        logic [olid_pkg::WORD_W-1:0]   word;
        logic [olid_pkg::INDEX_W-1:0]  index;
        logic [olid_pkg::COUNT_W-1:0]  count;
        logic                          last;
    } list_reply_t;

    typedef struct packed {
        list_cmd_t   cmd;
        logic        typed;
        list_reply_t want;
    } table_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [olid_pkg::S_DATA_W-1:0] s_tdata;
    logic [olid_pkg::OPCODE_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [olid_pkg::M_DATA_W-1:0] m_tdata;
    logic [olid_pkg::STATUS_W-1:0] m_tuser;
    logic                          m_tlast;

    logic [olid_pkg::WORD_W-1:0] shadow_words [CAPACITY];
    bit                          shadow_written [CAPACITY];
    int                          shadow_count;

    list_reply_t replies_due[$];
    table_row_t  directed_rows[$];
    int          error_count;
    int          burst_left;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    ordered_list_insert_delete_top #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    function automatic logic [SLOT_W-1:0] slot(input int n);
        return n[SLOT_W-1:0];
    endfunction

    task automatic push_reply(input logic [olid_pkg::STATUS_W-1:0] st,
                              input logic [olid_pkg::WORD_W-1:0] w,
                              input int idx, input bit lst);
        list_reply_t r;
        r.status = st;
        r.word   = w;
        r.index  = idx[olid_pkg::INDEX_W-1:0];
        r.count  = shadow_count[olid_pkg::COUNT_W-1:0];
        r.last   = lst;
        replies_due.push_back(r);
    endtask

    // Updates the shadow list and queues every reply the op causes.
    task automatic apply_list_op(input list_cmd_t c);
        int p;
        int k;
        int cnt;
        logic [olid_pkg::WORD_W-1:0] old_word;
        p   = int'($signed(c.pos));
        cnt = shadow_count;
        case (c.op)
            olid_pkg::OP_LOAD: begin
                if (int'(c.lcnt) < 1 || int'(c.lcnt) > CAPACITY) begin
                    push_reply(olid_pkg::ST_BADCNT, '0, 0, 1'b1);
                end else if (p < 0 || p >= int'(c.lcnt)) begin
                    push_reply(olid_pkg::ST_BADIDX, '0, 0, 1'b1);
                end else begin
                    shadow_words[slot(p)]   = c.word;
                    shadow_written[slot(p)] = 1'b1;
                    shadow_count            = int'(c.lcnt);
                    push_reply(olid_pkg::ST_OK, '0, p, 1'b1);
                end
            end
            olid_pkg::OP_READ: begin
                if (cnt == 0) begin
                    push_reply(olid_pkg::ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (k = 0; k < cnt; k++)
                        push_reply(olid_pkg::ST_OK, shadow_words[slot(k)], k, k == cnt - 1);
                end
            end
            olid_pkg::OP_INSERT: begin
                if (cnt >= CAPACITY) begin
                    push_reply(olid_pkg::ST_FULL, '0, 0, 1'b1);
                end else begin
                    if (p < 0) p = 0;
                    else if (p > cnt) p = cnt;
                    for (k = cnt - 1; k >= p; k--) begin
                        shadow_words[slot(k + 1)]   = shadow_words[slot(k)];
                        shadow_written[slot(k + 1)] = shadow_written[slot(k)];
                    end
                    shadow_words[slot(p)]   = c.word;
                    shadow_written[slot(p)] = 1'b1;
                    shadow_count            = cnt + 1;
                    push_reply(olid_pkg::ST_OK, '0, p, 1'b1);
                end
            end
            olid_pkg::OP_EDIT: begin
                if (p < 0 || p >= cnt) begin
                    push_reply(olid_pkg::ST_BADIDX, '0, 0, 1'b1);
                end else begin
                    old_word              = shadow_words[slot(p)];
                    shadow_words[slot(p)] = c.word;
                    push_reply(olid_pkg::ST_OK, old_word, p, 1'b1);
                end
            end
            olid_pkg::OP_DELETE: begin
                if (p < 0 || p >= cnt) begin
                    push_reply(olid_pkg::ST_BADIDX, '0, 0, 1'b1);
                end else begin
                    for (k = p; k < cnt - 1; k++) begin
                        shadow_words[slot(k)]   = shadow_words[slot(k + 1)];
                        shadow_written[slot(k)] = shadow_written[slot(k + 1)];
                    end
                    shadow_count = cnt - 1;
                    push_reply(olid_pkg::ST_OK, '0, p, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // Highest load count that leaves no unwritten word below the count,
    // given a write at index p.
    function automatic int load_limit(input int p);
        int n;
        n = 0;
        while (n < CAPACITY && (n == p || shadow_written[slot(n)])) n++;
        return n;
    endfunction

    task automatic add_row(input logic [olid_pkg::OPCODE_W-1:0] op, input int pos,
                           input logic [olid_pkg::WORD_W-1:0] w, input int lcnt,
                           input bit typed, input logic [olid_pkg::STATUS_W-1:0] st,
                           input int idx, input int cnt);
        table_row_t row;
        row.cmd.op       = op;
        row.cmd.pos      = pos[olid_pkg::POS_W-1:0];
        row.cmd.word     = w;
        row.cmd.lcnt     = lcnt[olid_pkg::LCOUNT_W-1:0];
        row.typed        = typed;
        row.want.status  = st;
        row.want.word    = '0;
        row.want.index   = idx[olid_pkg::INDEX_W-1:0];
        row.want.count   = cnt[olid_pkg::COUNT_W-1:0];
        row.want.last    = 1'b1;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed_rows();
        add_row(olid_pkg::OP_READ,      0, 32'h0,          0, 1, olid_pkg::ST_EMPTY,  0, 0);
        add_row(olid_pkg::OP_EDIT,      0, 32'h1,          0, 1, olid_pkg::ST_BADIDX, 0, 0);
        add_row(olid_pkg::OP_DELETE,    0, 32'h0,          0, 1, olid_pkg::ST_BADIDX, 0, 0);
        add_row(olid_pkg::OP_LOAD,      0, 32'h1234_5678,  0, 1, olid_pkg::ST_BADCNT, 0, 0);
        add_row(olid_pkg::OP_LOAD,      0, 32'h1234_5678,  9, 1, olid_pkg::ST_BADCNT, 0, 0);
        add_row(olid_pkg::OP_LOAD,    127, 32'hFFFF_FFFF, 127, 1, olid_pkg::ST_BADCNT, 0, 0);
        add_row(olid_pkg::OP_LOAD,      1, 32'h0000_0001,  1, 1, olid_pkg::ST_BADIDX, 0, 0);
        add_row(olid_pkg::OP_LOAD,   -128, 32'h0000_0001,  1, 1, olid_pkg::ST_BADIDX, 0, 0);
        add_row(olid_pkg::OP_LOAD,      0, 32'h7FFF_FFFF,  1, 1, olid_pkg::ST_OK,     0, 1);
        add_row(olid_pkg::OP_INSERT, -128, 32'h8000_0000,  0, 1, olid_pkg::ST_OK,     0, 2);
        add_row(olid_pkg::OP_INSERT,  127, 32'hFFFF_FFFF,  0, 1, olid_pkg::ST_OK,     2, 3);
        add_row(olid_pkg::OP_READ,      0, 32'h0,          0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_EDIT,      1, 32'h0,          0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_EDIT,      3, 32'h0,          0, 1, olid_pkg::ST_BADIDX, 0, 3);
        add_row(olid_pkg::OP_DELETE,    0, 32'h0,          0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_DELETE,   -1, 32'h0,          0, 1, olid_pkg::ST_BADIDX, 0, 2);
        add_row(OP_RSVD_FIRST,          0, 32'hDEAD_BEEF,  1, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,    1, 32'h0000_0011,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,    0, 32'h0000_0022,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,  127, 32'h0000_0033,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,    3, 32'h0000_0044,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,   -1, 32'h0000_0055,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,    5, 32'h0000_0066,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_INSERT,    2, 32'h0000_0077,  0, 1, olid_pkg::ST_FULL,   0, 8);
        add_row(olid_pkg::OP_READ,      0, 32'h0,          0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_EDIT,      7, 32'h5A5A_5A5A,  0, 0, olid_pkg::ST_OK,     0, 0);
        add_row(olid_pkg::OP_DELETE,    7, 32'h0,          0, 0, olid_pkg::ST_OK,     0, 0);
    endtask

    task automatic next_random_cmd(output list_cmd_t c);
        int sel;
        int p;
        int lim;
        c.pos  = olid_pkg::POS_W'($urandom);
        c.lcnt = olid_pkg::LCOUNT_W'($urandom);
        case ($urandom_range(0, 11))
            0:       c.word = 32'h8000_0000;
            1:       c.word = 32'h7FFF_FFFF;
            default: c.word = $urandom;
        endcase
        sel = int'($urandom_range(0, 99));
        if (sel < 4) begin
            c.op = olid_pkg::OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end else if (sel < 22) begin
            c.op = olid_pkg::OP_LOAD;
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 1) != 0)
                        lim = 0;
                    else
                        lim = int'($urandom_range(CAPACITY + 1, 127));
                    c.lcnt = olid_pkg::LCOUNT_W'(lim);
                end
                1: begin
                    c.lcnt = olid_pkg::LCOUNT_W'($urandom_range(1, CAPACITY));
                    if ($urandom_range(0, 1) != 0)
                        p = int'($urandom_range(int'(c.lcnt), 127));
                    else
                        p = 256 - int'($urandom_range(1, 128));
                    c.pos = olid_pkg::POS_W'(p);
                end
                default: begin
                    p = int'($urandom_range(0, CAPACITY - 1));
                    if (load_limit(p) <= p) p = load_limit(-1);
                    lim    = load_limit(p);
                    c.pos  = olid_pkg::POS_W'(p);
                    c.lcnt = olid_pkg::LCOUNT_W'($urandom_range(p + 1, lim));
                end
            endcase
        end else if (sel < 34) begin
            c.op = olid_pkg::OP_READ;
        end else if (sel < 60) begin
            c.op = olid_pkg::OP_INSERT;
            if ($urandom_range(0, 3) != 0)
                c.pos = olid_pkg::POS_W'($urandom_range(0, shadow_count));
        end else begin
            c.op = (sel < 78) ? olid_pkg::OP_EDIT : olid_pkg::OP_DELETE;
            if (shadow_count > 0 && $urandom_range(0, 4) != 0)
                c.pos = olid_pkg::POS_W'($urandom_range(0, shadow_count - 1));
        end
    endtask

    // Offers one command in the current burst and waits for its transfer.
    task automatic issue_cmd(input list_cmd_t c, input bit typed, input list_reply_t want);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {1'b0, c.lcnt, c.word, c.pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_list_op(c);
        if (typed) begin
            void'(replies_due.pop_back());
            replies_due.push_back(want);
        end
    endtask

    initial begin : stimulus
        int k;
        int done_ops;
        list_cmd_t c;
        list_reply_t none;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= olid_pkg::OP_LOAD;
        error_count  = 0;
        burst_left   = 0;
        shadow_count = 0;
        none         = '0;
        for (k = 0; k < CAPACITY; k++) begin
            shadow_words[slot(k)]   = '0;
            shadow_written[slot(k)] = 1'b0;
        end
        build_directed_rows();
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        done_ops = 0;
        while (done_ops < RANDOM_OPS) begin
            next_random_cmd(c);
            if (c.op < OP_RSVD_FIRST) done_ops++;
            issue_cmd(c, 1'b0, none);
        end
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_LEN) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random ready patterns, with a long hold-off now and then.
    initial begin : receiver
        int seg;
        int len;
        int mode;
        int n;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        seg = 0;
        forever begin
            if (seg % 12 == 3) begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_OFF; n++) @(posedge aclk);
            end else begin
                mode = int'($urandom_range(0, 3));
                len  = int'($urandom_range(10, 60));
                for (n = 0; n < len; n++) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (n % 5 > 1);
                    endcase
                    @(posedge aclk);
                end
            end
            seg++;
        end
    end

    always @(posedge aclk) begin : reply_check
        list_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result transfer: status %0d word %h",
                       m_tuser, m_tdata[31:0]);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[31:0] !== want.word) begin
                    $error("word_out: expected %h, actual %h", want.word, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[37:32] !== want.index) begin
                    $error("word_index: expected %0d, actual %0d", want.index, m_tdata[37:32]);
                    error_count++;
                end
                if (m_tdata[44:38] !== want.count) begin
                    $error("count_now: expected %0d, actual %0d", want.count, m_tdata[44:38]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/olid_pkg.sv
rtl/core/olid_cell.sv
rtl/core/ordered_list_insert_delete_top.sv
rtl/core/olid_checker.sv
dv/tb_ordered_list_insert_delete_top.sv
